>>> sv/slab_bitmap_allocator_assert.svh
// assertion helpers used by the allocator rtl
`ifndef SLAB_BITMAP_ALLOCATOR_ASSERT_SVH
`define SLAB_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, held off during reset
`define SBA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define SBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/sba_pkg.sv
`default_nettype none

package sba_pkg;

   // payload field widths
   localparam int OPCODE_W = 1;
   localparam int SIZE_W   = 12;
   localparam int PAGE_W   = 3;
   localparam int SLOT_W   = 8;
   localparam int STATUS_W = 2;
   localparam int CLASS_W  = 3;
   localparam int OFFSET_W = 12;
   localparam int USED_W   = 12;
   localparam int PCOUNT_W = 4;

   // smallest object is 16 bytes, classes double from there
   localparam int MIN_OBJ     = 16;
   localparam int MIN_OBJ_LOG = 4;

   // bitmap word geometry
   localparam int WORD_W   = 64;
   localparam int WORD_LOG = 6;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_TOO_LARGE = 2'd2,
      ST_BAD_FREE  = 2'd3
   } status_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CLASS_W-1:0]  size_class;
      logic [PAGE_W-1:0]   page_index;
      logic [SLOT_W-1:0]   slot_index;
      logic [OFFSET_W-1:0] byte_offset;
      logic [USED_W-1:0]   used_count;
      logic [PCOUNT_W-1:0] page_count;
   } rsp_type;

endpackage

`default_nettype wire

>>> sv/sba_req_if.sv
`default_nettype none

interface sba_req_if
   import sba_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [SIZE_W-1:0]   req_size;
   logic [PAGE_W-1:0]   free_page;
   logic [SLOT_W-1:0]   free_slot;

   modport source (
      output valid, opcode, req_size, free_page, free_slot,
      input  ready
   );

   modport sink (
      input  valid, opcode, req_size, free_page, free_slot,
      output ready
   );
endinterface

`default_nettype wire

>>> sv/sba_rsp_if.sv
`default_nettype none

interface sba_rsp_if
   import sba_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [CLASS_W-1:0]  size_class;
   logic [PAGE_W-1:0]   page_index;
   logic [SLOT_W-1:0]   slot_index;
   logic [OFFSET_W-1:0] byte_offset;
   logic [USED_W-1:0]   used_count;
   logic [PCOUNT_W-1:0] page_count;

   modport source (
      output valid, status, size_class, page_index, slot_index, byte_offset,
             used_count, page_count,
      input  ready
   );

   modport sink (
      input  valid, status, size_class, page_index, slot_index, byte_offset,
             used_count, page_count,
      output ready
   );
endinterface

`default_nettype wire

>>> sv/sba_bitmap_ram.sv
`default_nettype none

module sba_bitmap_ram
   import sba_pkg::*;
#(
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WORD_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/sba_zero_find.sv
`default_nettype none

module sba_zero_find
   import sba_pkg::*;
(
   input  wire logic [WORD_W-1:0]   word,
   output logic                     found,
   output logic [WORD_LOG-1:0]      pos
);

   localparam int GRP_LOG = WORD_LOG - 3;
   localparam int GROUPS  = WORD_W / 8;

   logic [GROUPS-1:0]  grp_zero;
   logic [GRP_LOG-1:0] grp;
   logic [7:0]         grp_bits;
   logic [2:0]         bit_sel;

   // two short priority levels: first byte holding a zero, then the bit in it
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_zero[g] = ~&word[8*g +: 8];
      end
      grp = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_zero[g]) begin
            grp = GRP_LOG'(g);
         end
      end
      grp_bits = word[8*grp +: 8];
      bit_sel  = '0;
      for (int b = 7; b >= 0; b--) begin
         if (!grp_bits[b]) begin
            bit_sel = 3'(b);
         end
      end
   end

   assign found = |grp_zero;
   assign pos   = {grp, bit_sel};

endmodule

`default_nettype wire

>>> sv/slab_bitmap_allocator.sv
// channel | dir | handshake           | payload
// req_ch  | in  | valid/ready         | opcode, req_size, free_page, free_slot
// rsp_ch  | out | valid/ready         | status, size_class, page_index, slot_index,
//         |     |                     | byte_offset, used_count, page_count
//
// allocate: scans the class's bitmap words in order on the one read port and, unless the
// class is full, reads the chosen word and writes it back with the bit set; free: if the
// handle is in range, reads the word and clears the bit if set; oversize: no bitmap access
// after reset a clearing pass writes every bitmap row, 256 rows by default
// one item at a time; the next beat is taken while a result still waits on rsp_ch
// PAGE_BYTES must be a power of two
`default_nettype none

`include "slab_bitmap_allocator_assert.svh"

module slab_bitmap_allocator
   import sba_pkg::*;
#(
   parameter int NUM_CLASSES = 8,
   parameter int PAGE_BYTES  = 4096,
   parameter int MAX_PAGES   = 8
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sba_req_if.sink    req_ch,
   sba_rsp_if.source  rsp_ch
);

   localparam int PAGE_LOG       = $clog2(PAGE_BYTES);
   localparam int BITS_PER_CLASS = (PAGE_BYTES / MIN_OBJ) * MAX_PAGES;
   localparam int WPC            = (BITS_PER_CLASS + WORD_W - 1) / WORD_W;
   localparam int WW             = $clog2(WPC);
   localparam int CW             = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int AW             = CW + WW;
   localparam int IDX_W          = WW + WORD_LOG;
   localparam int TOT_W          = IDX_W + 1;
   localparam int PGC_W          = $clog2(MAX_PAGES + 1);
   localparam int UC_W           = $clog2(BITS_PER_CLASS + 1);
   localparam int SL_W           = $clog2(PAGE_LOG - MIN_OBJ_LOG + 1);
   localparam int CMP_W          = (PGC_W > PAGE_W) ? PGC_W : PAGE_W;
   localparam int SH_W           = $clog2(MIN_OBJ_LOG + NUM_CLASSES);

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_SETUP  = 7'b0000100,
      S_SCAN   = 7'b0001000,
      S_RMW_RD = 7'b0010000,
      S_RMW_WR = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   // control
   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PGC_W-1:0]  class_pages_ff [NUM_CLASSES];
   logic [UC_W-1:0]   class_used_ff [NUM_CLASSES];

   // payload
   logic              op_ff, op_in;
   logic              big_ff, big_in;
   logic [CW-1:0]     cls_ff, cls_in;
   logic [PAGE_W-1:0] fpage_ff, fpage_in;
   logic [SLOT_W-1:0] fslot_ff, fslot_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [WW-1:0]     last_ff, last_in;
   logic [WW-1:0]     word_ff, word_in;
   logic [WW-1:0]     chk_ff, chk_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              grow_ff, grow_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // class table update
   logic              cls_we;
   logic [PGC_W-1:0]  new_pages;
   logic [UC_W-1:0]   new_used;

   // bitmap port
   logic              ram_we;
   logic [AW-1:0]     ram_wa, ram_ra;
   logic [WORD_W-1:0] ram_wd, rd_data;

   // datapath
   logic              sel_big;
   logic [CW-1:0]     sel_cls;
   logic [PGC_W-1:0]  cur_pages;
   logic [UC_W-1:0]   cur_used;
   logic [SL_W-1:0]   cur_plog;
   logic [TOT_W-1:0]  cur_total;
   logic [TOT_W-1:0]  slot_cnt;
   logic [IDX_W-1:0]  free_idx;
   logic              free_ok;
   logic              zf_found;
   logic [WORD_LOG-1:0] zf_pos;
   logic [IDX_W-1:0]  scan_idx;
   logic              scan_hit;
   logic              word_bit;
   logic [WORD_W-1:0] bit_mask;
   logic [TOT_W-1:0]  out_slot;
   logic [TOT_W-1:0]  out_page;
   logic [SH_W-1:0]   off_sh;
   rsp_type           res_reject;

   sba_bitmap_ram #(
      .ADDR_W (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (rd_data)
   );

   sba_zero_find u_zf (
      .word  (rd_data),
      .found (zf_found),
      .pos   (zf_pos)
   );

   // smallest class whose object size covers the request
   always_comb begin
      sel_cls = '0;
      sel_big = 1'b1;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (req_ch.req_size <= SIZE_W'(MIN_OBJ << c)) begin
            sel_cls = CW'(c);
            sel_big = 1'b0;
         end
      end
   end

   always_comb begin
      cur_pages = class_pages_ff[cls_ff];
      cur_used  = class_used_ff[cls_ff];
      cur_plog  = SL_W'(PAGE_LOG - MIN_OBJ_LOG) - SL_W'(cls_ff);
      cur_total = TOT_W'(cur_pages) << cur_plog;
      slot_cnt  = TOT_W'(1) << cur_plog;
      free_idx  = (IDX_W'(fpage_ff) << cur_plog) + IDX_W'(fslot_ff);
      free_ok   = (CMP_W'(fpage_ff) < CMP_W'(cur_pages)) &&
                  ((TOT_W'(fslot_ff) >> cur_plog) == '0);
      scan_idx  = {chk_ff, zf_pos};
      // bits at or past the class total are never set, so a clear bit there means full
      scan_hit  = zf_found && (TOT_W'(scan_idx) < total_ff);
      word_bit  = rd_data[idx_ff[WORD_LOG-1:0]];
      bit_mask  = WORD_W'(1) << idx_ff[WORD_LOG-1:0];
      out_slot  = TOT_W'(idx_ff) & (slot_cnt - TOT_W'(1));
      out_page  = TOT_W'(idx_ff) >> cur_plog;
      off_sh    = SH_W'(MIN_OBJ_LOG) + SH_W'(cls_ff);

      res_reject             = '0;
      res_reject.size_class  = CLASS_W'(cls_ff);
      res_reject.used_count  = USED_W'(cur_used);
      res_reject.page_count  = PCOUNT_W'(cur_pages);
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      op_in        = op_ff;
      big_in       = big_ff;
      cls_in       = cls_ff;
      fpage_in     = fpage_ff;
      fslot_in     = fslot_ff;
      total_in     = total_ff;
      last_in      = last_ff;
      word_in      = word_ff;
      chk_in       = chk_ff;
      idx_in       = idx_ff;
      grow_in      = grow_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      cls_we       = 1'b0;
      new_pages    = cur_pages;
      new_used     = cur_used;
      ram_we       = 1'b0;
      ram_wa       = {cls_ff, idx_ff[IDX_W-1:WORD_LOG]};
      ram_wd       = '0;
      ram_ra       = {cls_ff, word_ff};

      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            ram_wa = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.opcode;
               big_in   = sel_big;
               cls_in   = sel_cls;
               fpage_in = req_ch.free_page;
               fslot_in = req_ch.free_slot;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            total_in = cur_total;
            last_in  = WW'((cur_total - TOT_W'(1)) >> WORD_LOG);
            word_in  = '0;
            pend_in  = 1'b0;
            grow_in  = 1'b0;
            if (big_ff) begin
               res_in        = '0;
               res_in.status = ST_TOO_LARGE;
               state_in      = S_DONE;
            end else if (op_ff == OP_FREE) begin
               if (free_ok) begin
                  idx_in   = free_idx;
                  state_in = S_RMW_RD;
               end else begin
                  res_in        = res_reject;
                  res_in.status = ST_BAD_FREE;
                  state_in      = S_DONE;
               end
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // one word read per cycle, checked the cycle after
            if (pend_ff && scan_hit) begin
               idx_in   = scan_idx;
               state_in = S_RMW_RD;
            end else if (pend_ff && (zf_found || chk_ff == last_ff)) begin
               if (cur_pages >= PGC_W'(MAX_PAGES)) begin
                  res_in        = res_reject;
                  res_in.status = ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  // open a new page, its slot 0 sits right at the old total
                  idx_in   = IDX_W'(total_ff);
                  grow_in  = 1'b1;
                  state_in = S_RMW_RD;
               end
            end else begin
               chk_in  = word_ff;
               word_in = word_ff + WW'(1);
               pend_in = 1'b1;
            end
         end
         S_RMW_RD: begin
            ram_ra   = {cls_ff, idx_ff[IDX_W-1:WORD_LOG]};
            state_in = S_RMW_WR;
         end
         S_RMW_WR: begin
            if (op_ff == OP_FREE && !word_bit) begin
               res_in        = res_reject;
               res_in.status = ST_BAD_FREE;
            end else begin
               ram_we    = 1'b1;
               ram_wd    = (op_ff == OP_FREE) ? (rd_data & ~bit_mask) : (rd_data | bit_mask);
               cls_we    = 1'b1;
               new_used  = (op_ff == OP_FREE) ? (cur_used - UC_W'(1)) : (cur_used + UC_W'(1));
               new_pages = grow_ff ? (cur_pages + PGC_W'(1)) : cur_pages;
               res_in.status      = ST_OK;
               res_in.size_class  = CLASS_W'(cls_ff);
               res_in.page_index  = PAGE_W'(out_page);
               res_in.slot_index  = SLOT_W'(out_slot);
               res_in.byte_offset = OFFSET_W'(out_slot) << off_sh;
               res_in.used_count  = USED_W'(new_used);
               res_in.page_count  = PCOUNT_W'(new_pages);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            class_pages_ff[c] <= PGC_W'(1);
            class_used_ff[c]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cls_we) begin
            class_pages_ff[cls_ff] <= new_pages;
            class_used_ff[cls_ff]  <= new_used;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      big_ff      <= big_in;
      cls_ff      <= cls_in;
      fpage_ff    <= fpage_in;
      fslot_ff    <= fslot_in;
      total_ff    <= total_in;
      last_ff     <= last_in;
      word_ff     <= word_in;
      chk_ff      <= chk_in;
      idx_ff      <= idx_in;
      grow_ff     <= grow_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_data_ff.status;
   assign rsp_ch.size_class  = rsp_data_ff.size_class;
   assign rsp_ch.page_index  = rsp_data_ff.page_index;
   assign rsp_ch.slot_index  = rsp_data_ff.slot_index;
   assign rsp_ch.byte_offset = rsp_data_ff.byte_offset;
   assign rsp_ch.used_count  = rsp_data_ff.used_count;
   assign rsp_ch.page_count  = rsp_data_ff.page_count;

   // an allocation only ever claims a slot whose bit is clear
   `SBA_ASSERT_IMPLY(a_alloc_clear_bit, clock, reset,
      state_ff == S_RMW_WR && op_ff == OP_ALLOC, !word_bit,
      "allocation hit a slot already in use")

   // a good free never underflows the class count
   `SBA_ASSERT_IMPLY(a_free_count, clock, reset,
      state_ff == S_RMW_WR && op_ff == OP_FREE && word_bit, cur_used != '0,
      "free with zero objects in use")

   // a class only grows below its page limit
   `SBA_ASSERT_IMPLY(a_grow_limit, clock, reset,
      state_ff == S_RMW_WR && grow_ff, cur_pages < PGC_W'(MAX_PAGES),
      "class grew past its page limit")

   // the scan never checks a word past the class end
   `SBA_ASSERT_IMPLY(a_scan_range, clock, reset,
      state_ff == S_SCAN && pend_ff, chk_ff <= last_ff,
      "bitmap scan ran past the last word")

   // a finished result lands on the output and the block goes back to idle
   `SBA_ASSERT_NEXT(a_result_out, clock, reset,
      state_ff == S_DONE && (!rsp_valid_ff || rsp_ch.ready),
      rsp_valid_ff && state_ff == S_IDLE,
      "result not delivered from done")

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb
   import sba_pkg::*;
();

   localparam int CLASS_COUNT = 8;
   localparam int PAGE_SIZE   = 4096;
   localparam int PAGE_LIMIT  = 8;
   localparam int SLOT_SPACE  = (PAGE_SIZE / MIN_OBJ) * PAGE_LIMIT;
   localparam int QUIET_LIMIT = 4000;
   localparam int SHOWN_ERRS  = 10;

   typedef struct {
      logic [CLASS_W-1:0] cls;
      logic [PAGE_W-1:0]  page;
      logic [SLOT_W-1:0]  slot;
   } slab_handle_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sba_req_if req_ch();
   sba_rsp_if rsp_ch();

   slab_bitmap_allocator #(
      .NUM_CLASSES (CLASS_COUNT),
      .PAGE_BYTES  (PAGE_SIZE),
      .MAX_PAGES   (PAGE_LIMIT)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // mirror of the allocator state
   bit usage_map [CLASS_COUNT][SLOT_SPACE];
   int pages_held [CLASS_COUNT] = '{default: 1};
   int used_in_class [CLASS_COUNT] = '{default: 0};

   rsp_type pending_rsps[$];
   slab_handle_type live_objects[$];
   slab_handle_type freed_last;
   bit have_freed = 1'b0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_left = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;
   rsp_type seen_rsp;
   rsp_type want_rsp;

   always begin
      #1;
      clock = 1'b1;
      #1;
      clock = 1'b0;
   end

   function automatic rsp_type allocator_step(logic op, logic [SIZE_W-1:0] size,
                                              logic [PAGE_W-1:0] fpage,
                                              logic [SLOT_W-1:0] fslot);
      rsp_type r;
      int cls;
      int per;
      int total;
      int idx;
      r = '0;
      cls = -1;
      for (int c = CLASS_COUNT - 1; c >= 0; c--)
         if (size <= (MIN_OBJ << c)) cls = c;
      if (cls < 0) begin
         r.status = ST_TOO_LARGE;
         return r;
      end
      per = PAGE_SIZE / (MIN_OBJ << cls);
      r.size_class = CLASS_W'(cls);
      if (op == OP_ALLOC) begin
         total = per * pages_held[cls];
         idx = total;
         for (int i = total - 1; i >= 0; i--)
            if (!usage_map[cls][i]) idx = i;
         if (idx == total && pages_held[cls] >= PAGE_LIMIT) begin
            r.status = ST_FULL;
         end else begin
            // every slot taken: open the next page and use its first slot
            if (idx == total) pages_held[cls]++;
            usage_map[cls][idx] = 1'b1;
            used_in_class[cls]++;
            r.status = ST_OK;
            r.page_index = PAGE_W'(idx / per);
            r.slot_index = SLOT_W'(idx % per);
            r.byte_offset = OFFSET_W'((idx % per) * (MIN_OBJ << cls));
         end
      end else if (fpage >= pages_held[cls] || fslot >= per ||
                   !usage_map[cls][fpage * per + fslot]) begin
         r.status = ST_BAD_FREE;
      end else begin
         usage_map[cls][fpage * per + fslot] = 1'b0;
         used_in_class[cls]--;
         r.status = ST_OK;
         r.page_index = fpage;
         r.slot_index = fslot;
         r.byte_offset = OFFSET_W'(fslot * (MIN_OBJ << cls));
      end
      r.used_count = USED_W'(used_in_class[cls]);
      r.page_count = PCOUNT_W'(pages_held[cls]);
      return r;
   endfunction

   function automatic logic [SIZE_W-1:0] size_in_class(int c);
      if (c == 0) return SIZE_W'($urandom_range(MIN_OBJ, 0));
      return SIZE_W'($urandom_range(MIN_OBJ << c, (MIN_OBJ << (c - 1)) + 1));
   endfunction

   function automatic string show_rsp(rsp_type r);
      return $sformatf("st=%0d cls=%0d pg=%0d sl=%0d off=%0d used=%0d pages=%0d",
                       r.status, r.size_class, r.page_index, r.slot_index,
                       r.byte_offset, r.used_count, r.page_count);
   endfunction

   task automatic flag_error(string msg);
      mismatch_count++;
      if (mismatch_count <= SHOWN_ERRS) $display("[%0t] %s", $realtime, msg);
   endtask

   // offers one request beat and books its expected result once taken
   task automatic send_item(logic op, logic [SIZE_W-1:0] size,
                            logic [PAGE_W-1:0] fpage, logic [SLOT_W-1:0] fslot);
      rsp_type exp;
      slab_handle_type h;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.opcode    <= op;
      req_ch.req_size  <= size;
      req_ch.free_page <= fpage;
      req_ch.free_slot <= fslot;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      exp = allocator_step(op, size, fpage, fslot);
      pending_rsps.push_back(exp);
      if (exp.status == ST_OK) begin
         h.cls = exp.size_class;
         h.page = exp.page_index;
         h.slot = exp.slot_index;
         if (op == OP_ALLOC) begin
            live_objects.push_back(h);
         end else begin
            foreach (live_objects[k])
               if (live_objects[k].cls == h.cls && live_objects[k].page == h.page &&
                   live_objects[k].slot == h.slot) begin
                  live_objects.delete(k);
                  break;
               end
            freed_last = h;
            have_freed = 1'b1;
         end
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_rsps.size() != 0);
   endtask

   task automatic test_directed_edges();
      send_item(OP_ALLOC, 12'd0, 3'd0, 8'd0);
      send_item(OP_ALLOC, 12'd16, 3'd7, 8'd255);
      send_item(OP_ALLOC, 12'd17, 3'd0, 8'd0);
      send_item(OP_ALLOC, 12'd2048, 3'd0, 8'd0);
      send_item(OP_ALLOC, 12'd2049, 3'd0, 8'd0);
      send_item(OP_ALLOC, 12'd4095, 3'd7, 8'd255);
      send_item(OP_FREE, 12'd4095, 3'd7, 8'd255);
      // page beyond the class, slot beyond the page, slot never taken
      send_item(OP_FREE, 12'd0, 3'd1, 8'd0);
      send_item(OP_FREE, 12'd2048, 3'd0, 8'd255);
      send_item(OP_FREE, 12'd100, 3'd0, 8'd0);
      send_item(OP_FREE, 12'd16, 3'd0, 8'd0);
      send_item(OP_FREE, 12'd16, 3'd0, 8'd0);
   endtask

   task automatic test_class_fill();
      // largest class: two slots a page, grows to the page limit then reports full
      repeat (16) send_item(OP_ALLOC, 12'd1500, 3'd0, 8'd0);
      send_item(OP_FREE, 12'd2000, 3'd7, 8'd1);
      send_item(OP_ALLOC, 12'd1025, 3'd0, 8'd0);
   endtask

   task automatic run_mixed_traffic(int n_items);
      int pick;
      int cls;
      int k;
      slab_handle_type h;
      repeat (n_items) begin
         pick = $urandom_range(99);
         if (pick >= 50 && pick < 80 && live_objects.size() > 0) begin
            k = $urandom_range(live_objects.size() - 1);
            h = live_objects[k];
            send_item(OP_FREE, size_in_class(int'(h.cls)), h.page, h.slot);
         end else if (pick >= 80 && pick < 88) begin
            cls = $urandom_range(CLASS_COUNT - 1);
            send_item(OP_FREE, size_in_class(cls), PAGE_W'($urandom_range(7)),
                      SLOT_W'($urandom_range(255)));
         end else if (pick >= 88 && pick < 93 && have_freed) begin
            send_item(OP_FREE, size_in_class(int'(freed_last.cls)), freed_last.page,
                      freed_last.slot);
         end else if (pick >= 93) begin
            send_item(1'($urandom_range(1)), SIZE_W'($urandom_range(4095)),
                      PAGE_W'($urandom_range(7)), SLOT_W'($urandom_range(255)));
         end else begin
            // lean on the big classes so they fill and hit the page limit
            cls = ($urandom_range(99) < 60) ? $urandom_range(7, 4) : $urandom_range(3, 0);
            send_item(OP_ALLOC, size_in_class(cls), PAGE_W'($urandom_range(7)),
                      SLOT_W'($urandom_range(255)));
         end
      end
   endtask

   task automatic test_output_stall();
      int saved_pct;
      saved_pct = send_idle_pct;
      send_idle_pct = 0;
      stall_left = 300;
      run_mixed_traffic(16);
      wait_drained();
      send_idle_pct = saved_pct;
   endtask

   initial begin
      req_ch.valid     <= 1'b0;
      req_ch.opcode    <= OP_ALLOC;
      req_ch.req_size  <= '0;
      req_ch.free_page <= '0;
      req_ch.free_slot <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 29;
      recv_idle_pct = 85;
      test_directed_edges();
      test_class_fill();
      run_mixed_traffic(540);
      test_output_stall();

      send_idle_pct = 85;
      recv_idle_pct = 29;
      run_mixed_traffic(540);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_mixed_traffic(540);

      wait_drained();
      repeat (64) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("slab_bitmap_allocator: match");
      end else begin
         $display("slab_bitmap_allocator: mismatch");
      end
      $finish;
   end

   // result side ready, with random idling and a counted hold-off
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         seen_rsp.status      = rsp_ch.status;
         seen_rsp.size_class  = rsp_ch.size_class;
         seen_rsp.page_index  = rsp_ch.page_index;
         seen_rsp.slot_index  = rsp_ch.slot_index;
         seen_rsp.byte_offset = rsp_ch.byte_offset;
         seen_rsp.used_count  = rsp_ch.used_count;
         seen_rsp.page_count  = rsp_ch.page_count;
         if (pending_rsps.size() == 0) begin
            flag_error({"rsp beat with nothing pending: ", show_rsp(seen_rsp)});
         end else begin
            want_rsp = pending_rsps.pop_front();
            if (seen_rsp.status !== want_rsp.status ||
                seen_rsp.size_class !== want_rsp.size_class ||
                seen_rsp.page_index !== want_rsp.page_index ||
                seen_rsp.slot_index !== want_rsp.slot_index ||
                seen_rsp.byte_offset !== want_rsp.byte_offset ||
                seen_rsp.used_count !== want_rsp.used_count ||
                seen_rsp.page_count !== want_rsp.page_count)
               flag_error({"rsp beat differs, exp ", show_rsp(want_rsp),
                           " got ", show_rsp(seen_rsp)});
         end
      end
   end

   // no beat on either side for too long means the block is hung
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("slab_bitmap_allocator: mismatch");
         $finish;
      end
   end

endmodule
